### rtl/cau_pkg.sv
// cau_pkg: shared constants, codes, record types and helper functions
// for the complex arithmetic unit
// no dependencies
package cau_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int PRESCALE     = 29;
    localparam int CORDIC_STEPS = 31;
    localparam int SQRT_STEPS   = 32;
    localparam int QUOT_BITS    = 33;
    localparam int ITER_STAGES  = QUOT_BITS + 1;
    localparam int REM_W        = 64 + FRAC_BITS;
    localparam int SHD_W        = 64 + QUOT_BITS;

    localparam logic [3:0] CMD_ADD = 4'd0;
    localparam logic [3:0] CMD_SUB = 4'd1;
    localparam logic [3:0] CMD_MUL = 4'd2;
    localparam logic [3:0] CMD_DIV = 4'd3;
    localparam logic [3:0] CMD_EQU = 4'd4;
    localparam logic [3:0] CMD_GTR = 4'd5;
    localparam logic [3:0] CMD_MOD = 4'd6;
    localparam logic [3:0] CMD_ARG = 4'd7;
    localparam logic [3:0] CMD_NEG = 4'd8;
    localparam logic [3:0] CMD_INC = 4'd9;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_DIV0 = 2'd1;
    localparam logic [1:0] ERR_SAT  = 2'd2;

    // pi/2 as given, rounded to the fraction width
    localparam logic [63:0] HALF_PI_Q =
        ((64'd31415 << FRAC_BITS) + 64'd10000) / 64'd20000;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } sat_t;

    typedef struct packed {
        logic [31:0] rr;
        logic [31:0] ri;
        logic        truth;
        logic [1:0]  err;
    } res_t;

    typedef struct packed {
        logic [3:0]             cmd;
        logic                   den_zero;
        logic                   re_zero;
        res_t                   simp;
        logic [63:0]            den;
        logic [REM_W-1:0]       rem_r;
        logic [REM_W-1:0]       rem_i;
        logic                   neg_r;
        logic                   neg_i;
        logic                   big_r;
        logic                   big_i;
        logic [QUOT_BITS-1:0]   q_r;
        logic [QUOT_BITS-1:0]   q_i;
        logic [63:0]            sq_s;
        logic [63:0]            sq_res;
        logic signed [63:0]     cx;
        logic signed [63:0]     cy;
        logic signed [63:0]     cz;
    } iter_t;

    // sign and magnitude to saturated 32-bit two's complement
    function automatic sat_t sat_mag(input logic neg, input logic [63:0] mag);
        sat_t r;
        r.sat = 1'b0;
        if (!neg) begin
            if (mag > 64'h7FFF_FFFF) begin
                r.val = 32'h7FFF_FFFF;
                r.sat = 1'b1;
            end else begin
                r.val = mag[31:0];
            end
        end else begin
            if (mag > 64'h8000_0000) begin
                r.val = 32'h8000_0000;
                r.sat = 1'b1;
            end else begin
                r.val = ~mag[31:0] + 32'd1;
            end
        end
        return r;
    endfunction

    // atan(2^-i) with 62 fraction bits by integer series, elaboration only
    function automatic logic [63:0] atan_pow2(input int i);
        logic [63:0] sum;
        logic [63:0] t;
        int          e;
        sum = '0;
        for (int k = 0; k < 32; k++) begin
            e = i * (2 * k + 1);
            if (e <= 62) begin
                t = (64'd1 << (62 - e)) / 64'(2 * k + 1);
                if ((k & 1) == 1) sum = sum - t;
                else sum = sum + t;
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] atan_third();
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] t;
        p   = (64'd1 << 62) / 64'd3;
        sum = '0;
        for (int k = 0; k < 40; k++) begin
            if (p != 64'd0) begin
                t = p / 64'(2 * k + 1);
                if ((k & 1) == 1) sum = sum - t;
                else sum = sum + t;
                p = p / 64'd9;
            end
        end
        return sum;
    endfunction

    // first entry is atan(1) = atan(1/2) + atan(1/3)
    function automatic logic [63:0] atan_entry(input int i);
        if (i == 0) return atan_pow2(1) + atan_third();
        return atan_pow2(i);
    endfunction

endpackage

### rtl/cau_iter_pipe.sv
// cau_iter_pipe: unrolled iteration pipeline, one step per stage for the
// restoring divider, the integer square root and the cordic vectoring unit
// depends on cau_pkg
module cau_iter_pipe import cau_pkg::*; (
    input  logic  clk,
    input  logic  rstn,
    input  logic  en,
    input  logic  in_valid,
    input  iter_t in_data,
    output logic  out_valid,
    output iter_t out_data
);

    logic [ITER_STAGES-1:0] vld_reg;
    iter_t                  st_reg [ITER_STAGES];
    iter_t                  st_in  [ITER_STAGES];
    iter_t                  st_next[ITER_STAGES];

    genvar j;
    generate
        for (j = 0; j < ITER_STAGES; j++) begin : g_stage
            localparam int K   = (j == 0) ? 0 : QUOT_BITS - j;
            localparam int SSH = (j < SQRT_STEPS) ? 62 - 2 * j : 0;
            localparam int CSH = (j < CORDIC_STEPS) ? j : 0;
            localparam logic [63:0]        SBIT = 64'd1 << SSH;
            localparam logic signed [63:0] TAB  = atan_entry(CSH);

            if (j == 0) begin : g_first
                assign st_in[j] = in_data;
            end else begin : g_next
                assign st_in[j] = st_reg[j-1];
            end

            always_comb begin
                logic [SHD_W-1:0]   dsh;
                logic [SHD_W-1:0]   rr_w;
                logic [SHD_W-1:0]   ri_w;
                logic [64:0]        trial;
                logic signed [63:0] xs;
                logic signed [63:0] ys;
                logic signed [63:0] cx;
                logic signed [63:0] cy;
                st_next[j] = st_in[j];
                rr_w = SHD_W'(st_in[j].rem_r);
                ri_w = SHD_W'(st_in[j].rem_i);
                // division: overflow check first, then one quotient bit a stage
                if (j == 0) begin
                    dsh = SHD_W'(st_in[j].den);
                    st_next[j].big_r = (rr_w >> QUOT_BITS) >= dsh;
                    st_next[j].big_i = (ri_w >> QUOT_BITS) >= dsh;
                end else begin
                    dsh = SHD_W'(st_in[j].den) << K;
                    if (rr_w >= dsh) begin
                        st_next[j].rem_r  = REM_W'(rr_w - dsh);
                        st_next[j].q_r[K] = 1'b1;
                    end
                    if (ri_w >= dsh) begin
                        st_next[j].rem_i  = REM_W'(ri_w - dsh);
                        st_next[j].q_i[K] = 1'b1;
                    end
                end
                // square root digit
                trial = {1'b0, st_in[j].sq_res} + {1'b0, SBIT};
                if (j < SQRT_STEPS) begin
                    if ({1'b0, st_in[j].sq_s} >= trial) begin
                        st_next[j].sq_s   = st_in[j].sq_s - trial[63:0];
                        st_next[j].sq_res = (st_in[j].sq_res >> 1) + SBIT;
                    end else begin
                        st_next[j].sq_res = st_in[j].sq_res >> 1;
                    end
                end
                // cordic rotation toward the x axis
                cx = st_in[j].cx;
                cy = st_in[j].cy;
                xs = cx >>> CSH;
                ys = cy >>> CSH;
                if (j < CORDIC_STEPS) begin
                    if (!cy[63]) begin
                        st_next[j].cx = cx + ys;
                        st_next[j].cy = cy - xs;
                        st_next[j].cz = st_in[j].cz + TAB;
                    end else begin
                        st_next[j].cx = cx - ys;
                        st_next[j].cy = cy + xs;
                        st_next[j].cz = st_in[j].cz - TAB;
                    end
                end
            end

            always_ff @(posedge clk) begin
                if (en) begin
                    st_reg[j] <= st_next[j];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk) begin
        if (!rstn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[ITER_STAGES-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[ITER_STAGES-1];
    assign out_data  = st_reg[ITER_STAGES-1];

endmodule

### rtl/complex_arithmetic_unit.sv
// complex_arithmetic_unit: top level, stream ports, product and sum stages,
// result selection and output register
// depends on cau_pkg and cau_iter_pipe
//
// Stateless complex ALU on signed Q16.16 operands. One beat in carries a
// command and the two operands a and b; one beat out carries the result, a
// truth bit for the compare commands and an error code. The block is a
// fixed pipeline of 37 register stages: one multiply stage, one sum stage,
// 34 iteration stages (an overflow check, then quotient bits, root digits
// and cordic steps side by side) and the output register. Every command
// takes the same path from input beat to output beat, and a new beat is taken
// every cycle; the whole pipeline holds when the output beat is not taken.
module complex_arithmetic_unit import cau_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // command [3:0], a_real [35:4], a_imag [67:36], b_real [99:68],
    // b_imag [131:100], zero fill [135:132]
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,
    // res_real [31:0], res_imag [63:32], truth [64], error [66:65],
    // zero fill [71:67]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata
);

    // pipeline advances whenever the output register is free or drained
    logic en;

    // input fields
    logic [3:0]         in_cmd;
    logic signed [31:0] in_ar;
    logic signed [31:0] in_ai;
    logic signed [31:0] in_br;
    logic signed [31:0] in_bi;
    logic [31:0]        mag_ar;
    logic [31:0]        mag_ai;
    logic [31:0]        mag_br;
    logic [31:0]        mag_bi;

    // stage 1: products and squares
    logic               v1_reg;
    logic [3:0]         cmd1_reg;
    logic signed [31:0] ar1_reg;
    logic signed [31:0] ai1_reg;
    logic signed [31:0] br1_reg;
    logic signed [31:0] bi1_reg;
    logic signed [63:0] p_rr_reg;
    logic signed [63:0] p_ii_reg;
    logic signed [63:0] p_ir_reg;
    logic signed [63:0] p_ri_reg;
    logic [63:0]        sq_ar_reg;
    logic [63:0]        sq_ai_reg;
    logic [63:0]        sq_br_reg;
    logic [63:0]        sq_bi_reg;

    // stage 2: sums, simple results, iteration seeds
    logic               v2_reg;
    iter_t              it2_reg;
    iter_t              it2_next;

    // iteration pipeline output
    logic               it_valid;
    iter_t              it_out;

    // output register
    logic               m_valid_reg;
    res_t               m_res_reg;
    res_t               m_res_next;

    assign en       = !m_valid_reg || m_tready;
    // no beat is taken while reset is held
    assign s_tready = en && aresetn;

    assign in_cmd = s_tdata[3:0];
    assign in_ar  = s_tdata[35:4];
    assign in_ai  = s_tdata[67:36];
    assign in_br  = s_tdata[99:68];
    assign in_bi  = s_tdata[131:100];

    assign mag_ar = in_ar[31] ? ~in_ar + 32'd1 : in_ar;
    assign mag_ai = in_ai[31] ? ~in_ai + 32'd1 : in_ai;
    assign mag_br = in_br[31] ? ~in_br + 32'd1 : in_br;
    assign mag_bi = in_bi[31] ? ~in_bi + 32'd1 : in_bi;

    // magnitude of a 65-bit exact sum of two products
    function automatic logic [63:0] mag65(input logic [64:0] s);
        logic [64:0] n;
        n = ~s + 65'd1;
        return s[64] ? n[63:0] : s[63:0];
    endfunction

    // saturate a 33-bit exact sum
    function automatic sat_t sat33(input logic [32:0] s);
        logic [32:0] m;
        m = s[32] ? ~s + 33'd1 : s;
        return sat_mag(s[32], 64'(m));
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= s_tvalid;
            v2_reg      <= v1_reg;
            m_valid_reg <= it_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd1_reg  <= in_cmd;
            ar1_reg   <= in_ar;
            ai1_reg   <= in_ai;
            br1_reg   <= in_br;
            bi1_reg   <= in_bi;
            p_rr_reg  <= in_ar * in_br;
            p_ii_reg  <= in_ai * in_bi;
            p_ir_reg  <= in_ai * in_br;
            p_ri_reg  <= in_ar * in_bi;
            sq_ar_reg <= 64'(mag_ar) * 64'(mag_ar);
            sq_ai_reg <= 64'(mag_ai) * 64'(mag_ai);
            sq_br_reg <= 64'(mag_br) * 64'(mag_br);
            sq_bi_reg <= 64'(mag_bi) * 64'(mag_bi);
            it2_reg   <= it2_next;
            m_res_reg <= m_res_next;
        end
    end

    // stage 2 logic
    always_comb begin
        logic [64:0]        s_mr;
        logic [64:0]        s_mi;
        logic [64:0]        s_dr;
        logic [64:0]        s_di;
        logic [63:0]        sq_a;
        logic [63:0]        den;
        logic signed [63:0] a64;
        logic signed [63:0] i64;
        sat_t               sr;
        sat_t               si;
        s_mr = 65'(p_rr_reg) - 65'(p_ii_reg);
        s_mi = 65'(p_ir_reg) + 65'(p_ri_reg);
        s_dr = 65'(p_rr_reg) + 65'(p_ii_reg);
        s_di = 65'(p_ir_reg) - 65'(p_ri_reg);
        sq_a = sq_ar_reg + sq_ai_reg;
        den  = sq_br_reg + sq_bi_reg;
        a64  = 64'(ar1_reg);
        i64  = 64'(ai1_reg);

        it2_next          = '0;
        it2_next.cmd      = cmd1_reg;
        it2_next.den_zero = (den == 64'd0);
        it2_next.re_zero  = (ar1_reg == 32'sd0);
        it2_next.den      = den;
        // divider seeds: numerator magnitude scaled by the fraction width
        it2_next.rem_r    = REM_W'(mag65(s_dr)) << FRAC_BITS;
        it2_next.rem_i    = REM_W'(mag65(s_di)) << FRAC_BITS;
        it2_next.neg_r    = s_dr[64];
        it2_next.neg_i    = s_di[64];
        // root seed
        it2_next.sq_s     = sq_a;
        // cordic seed in the right half plane
        it2_next.cx       = (ar1_reg[31] ? -a64 : a64) <<< PRESCALE;
        it2_next.cy       = (ar1_reg[31] ? -i64 : i64) <<< PRESCALE;

        sr = '0;
        si = '0;
        unique case (cmd1_reg)
            CMD_ADD: begin
                sr = sat33(33'(ar1_reg) + 33'(br1_reg));
                si = sat33(33'(ai1_reg) + 33'(bi1_reg));
            end
            CMD_SUB: begin
                sr = sat33(33'(ar1_reg) - 33'(br1_reg));
                si = sat33(33'(ai1_reg) - 33'(bi1_reg));
            end
            CMD_MUL: begin
                sr = sat_mag(s_mr[64], mag65(s_mr) >> FRAC_BITS);
                si = sat_mag(s_mi[64], mag65(s_mi) >> FRAC_BITS);
            end
            CMD_NEG: begin
                sr = sat33(33'd0 - 33'(ar1_reg));
                si = sat33(33'd0 - 33'(ai1_reg));
            end
            CMD_INC: begin
                sr     = sat33(33'(ar1_reg) + (33'd1 << FRAC_BITS));
                si.val = ai1_reg;
            end
            default: ;
        endcase
        it2_next.simp.rr  = sr.val;
        it2_next.simp.ri  = si.val;
        it2_next.simp.err = (sr.sat || si.sat) ? ERR_SAT : ERR_NONE;

        unique case (cmd1_reg)
            CMD_EQU: it2_next.simp.truth = (ar1_reg == br1_reg) && (ai1_reg == bi1_reg);
            CMD_GTR: it2_next.simp.truth = sq_a > den;
            CMD_DIV: if (den == 64'd0) it2_next.simp.err = ERR_DIV0;
            CMD_ARG: begin
                // real part zero: fixed quarter turn, sign of the imaginary part
                if (ar1_reg == 32'sd0) begin
                    it2_next.simp.rr = ai1_reg[31] ? 32'd0 - HALF_PI_Q[31:0]
                                                   : HALF_PI_Q[31:0];
                end
            end
            default: ;
        endcase
    end

    cau_iter_pipe u_iter (
        .clk       (aclk),
        .rstn      (aresetn),
        .en        (en),
        .in_valid  (v2_reg),
        .in_data   (it2_reg),
        .out_valid (it_valid),
        .out_data  (it_out)
    );

    // final selection, saturation and angle rounding
    always_comb begin
        logic [63:0] qr;
        logic [63:0] qi;
        logic [63:0] zm;
        logic [63:0] zr;
        sat_t        sr;
        sat_t        si;
        qr = it_out.big_r ? 64'h1_0000_0000 : 64'(it_out.q_r);
        qi = it_out.big_i ? 64'h1_0000_0000 : 64'(it_out.q_i);
        zm = it_out.cz[63] ? 64'd0 - it_out.cz : it_out.cz;
        zr = (zm + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
        sr = '0;
        si = '0;
        m_res_next = it_out.simp;
        unique case (it_out.cmd)
            CMD_DIV: begin
                if (!it_out.den_zero) begin
                    sr = sat_mag(it_out.neg_r, qr);
                    si = sat_mag(it_out.neg_i, qi);
                    m_res_next.rr  = sr.val;
                    m_res_next.ri  = si.val;
                    m_res_next.err = (sr.sat || si.sat) ? ERR_SAT : ERR_NONE;
                end
            end
            CMD_MOD: begin
                sr = sat_mag(1'b0, it_out.sq_res);
                m_res_next.rr  = sr.val;
                m_res_next.err = sr.sat ? ERR_SAT : ERR_NONE;
            end
            CMD_ARG: begin
                if (!it_out.re_zero) begin
                    m_res_next.rr = it_out.cz[63] ? 32'd0 - zr[31:0] : zr[31:0];
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_res_reg.err, m_res_reg.truth, m_res_reg.ri, m_res_reg.rr};

    // divide by zero returns zeros and no truth
    a_div0_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_res_reg.err == ERR_DIV0) |->
            (m_res_reg.rr == 32'd0) && (m_res_reg.ri == 32'd0) && !m_res_reg.truth)
        else $error("divide by zero beat carries data");

    // compare commands give no numeric result and no error
    a_truth_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_res_reg.truth |->
            (m_res_reg.rr == 32'd0) && (m_res_reg.ri == 32'd0) &&
            (m_res_reg.err == ERR_NONE))
        else $error("truth beat carries data or error");

    // an accepted beat enters the first stage
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted beat lost at pipeline entry");

endmodule
